// File: sv/bsm_pkg.sv
// shared widths, operation codes and decode helper for the booth multiplier
package bsm_pkg;

	// fixed field widths of the stream channels
	localparam int unsigned FIELD_W   = 16;
	localparam int unsigned PRODUCT_W = 32;
	localparam int unsigned S_DATA_W  = 2 * FIELD_W;
	localparam int unsigned M_DATA_W  = PRODUCT_W;

	// what one booth step does to the high half
	typedef enum logic [1:0] {
		BOOTH_HOLD = 2'b00,
		BOOTH_ADD  = 2'b01,
		BOOTH_SUB  = 2'b10
	} booth_op_t;

	// radix-2 recoding of the current low bit and the previous bit
	function automatic booth_op_t booth_decode(input logic cur, input logic prev);
		booth_op_t op;
		op = BOOTH_HOLD;
		if (cur && !prev) begin
			op = BOOTH_SUB;
		end else if (!cur && prev) begin
			op = BOOTH_ADD;
		end
		return op;
	endfunction

endpackage

// File: sv/bsm_step.sv
// one booth step: add or subtract, arithmetic shift, then a registered stage
module bsm_step #(
	parameter int unsigned OPERAND_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OPERAND_WIDTH:0]   in_addend,
	input  logic [OPERAND_WIDTH:0]   in_acc,
	input  logic [OPERAND_WIDTH-1:0] in_low,
	input  logic                     in_prev,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [OPERAND_WIDTH:0]   out_addend,
	output logic [OPERAND_WIDTH:0]   out_acc,
	output logic [OPERAND_WIDTH-1:0] out_low,
	output logic                     out_prev
);

	localparam int unsigned W = OPERAND_WIDTH;

	bsm_pkg::booth_op_t op;
	logic [W:0]   sum;
	logic [W:0]   acc_next;
	logic [W-1:0] low_next;
	logic         valid_s1;
	logic [W:0]   addend_s1;
	logic [W:0]   acc_s1;
	logic [W-1:0] low_s1;
	logic         prev_s1;
	logic         load;

	// recode and apply the add or subtract
	always_comb begin
		op = bsm_pkg::booth_decode(in_low[0], in_prev);
		case (op)
			bsm_pkg::BOOTH_ADD: sum = in_acc + in_addend;
			bsm_pkg::BOOTH_SUB: sum = in_acc - in_addend;
			default:            sum = in_acc;
		endcase
	end

	// arithmetic right shift of {acc, low}
	assign acc_next = {sum[W], sum[W:1]};
	assign low_next = {sum[0], in_low[W-1:1]};

	// stage takes an item when empty or when its item moves on
	assign in_ready = !valid_s1 || out_ready;
	assign load     = in_valid && in_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			addend_s1 <= in_addend;
			acc_s1    <= acc_next;
			low_s1    <= low_next;
			prev_s1   <= in_low[0];
		end
	end

	assign out_valid  = valid_s1;
	assign out_addend = addend_s1;
	assign out_acc    = acc_s1;
	assign out_low    = low_s1;
	assign out_prev   = prev_s1;

endmodule

// File: sv/booth_signed_multiplier.sv
// top level: pipelined radix-2 booth signed multiplier with stream channels
// Usage:
//   Operand pairs arrive on the s_ channel (s_tvalid, s_tready, s_tdata) and
//   products leave on the m_ channel (m_tvalid, m_tready, m_tdata). An item
//   moves when tvalid and tready are both high at a rising edge of clk.
//   s_tdata carries first_operand in bits 15:0 and second_operand in 31:16,
//   both two's complement; m_tdata carries the 32-bit signed product.
// Pipeline: one registered stage per booth step, the last stage driving m_tdata.
// Throughput: one item per cycle while m_tready is high; as many stages as
//   booth steps, each stage one add or subtract of OPERAND_WIDTH+1 bits.
// Reset: arst_n low clears every stage valid bit at once; no item is held.
// Stall: with m_tready low the last stage holds its product; earlier stages
//   keep filling empty slots, and s_tready falls only once every stage ahead
//   of the input holds an item. Nothing is dropped or repeated.
// Operands are sign-extended or wrapped to OPERAND_WIDTH bits; the product
//   is the low 32 bits of the 2*OPERAND_WIDTH-bit result, zero-filled above.
module booth_signed_multiplier #(
	parameter int unsigned OPERAND_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// fields from bit 0: first_operand[15:0], second_operand[31:16]
	input  logic [bsm_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// fields from bit 0: product[31:0]
	output logic [bsm_pkg::M_DATA_W-1:0]  m_tdata
);

	localparam int unsigned W   = OPERAND_WIDTH;
	localparam int unsigned FW  = bsm_pkg::FIELD_W;
	localparam int unsigned PW  = 2 * W;
	localparam int unsigned OW  = bsm_pkg::PRODUCT_W;

	logic [FW-1:0] first_op;
	logic [FW-1:0] second_op;
	logic [W:0]    addend_in;
	logic [W-1:0]  low_in;
	logic [PW-1:0] wide_product;

	// per-stage links, index 0 is the input side
	logic          valid_p  [0:W];
	logic          ready_p  [0:W];
	logic [W:0]    addend_p [0:W];
	logic [W:0]    acc_p    [0:W];
	logic [W-1:0]  low_p    [0:W];
	logic          prev_p   [0:W];

	assign first_op  = s_tdata[FW-1:0];
	assign second_op = s_tdata[2*FW-1:FW];

	// bring the operands to OPERAND_WIDTH bits
	generate
		if (W >= FW) begin : g_wide_in
			assign addend_in = {{(W + 1 - FW){first_op[FW-1]}}, first_op};
			if (W > FW) begin : g_low_ext
				assign low_in = {{(W - FW){second_op[FW-1]}}, second_op};
			end else begin : g_low_eq
				assign low_in = second_op;
			end
		end else begin : g_narrow_in
			assign addend_in = {first_op[W-1], first_op[W-1:0]};
			assign low_in    = second_op[W-1:0];
		end
	endgenerate

	// first stage input: accumulator clear, previous bit zero
	assign valid_p[0]  = s_tvalid;
	assign s_tready    = ready_p[0];
	assign addend_p[0] = addend_in;
	assign acc_p[0]    = '0;
	assign low_p[0]    = low_in;
	assign prev_p[0]   = 1'b0;

	// one registered stage per booth step
	generate
		for (genvar i = 0; i < W; i++) begin : g_step
			bsm_step #(
				.OPERAND_WIDTH(W)
			) u_step (
				.clk        (clk),
				.arst_n     (arst_n),
				.in_valid   (valid_p[i]),
				.in_ready   (ready_p[i]),
				.in_addend  (addend_p[i]),
				.in_acc     (acc_p[i]),
				.in_low     (low_p[i]),
				.in_prev    (prev_p[i]),
				.out_valid  (valid_p[i+1]),
				.out_ready  (ready_p[i+1]),
				.out_addend (addend_p[i+1]),
				.out_acc    (acc_p[i+1]),
				.out_low    (low_p[i+1]),
				.out_prev   (prev_p[i+1])
			);
		end
	endgenerate

	// last stage drives the output channel
	assign m_tvalid     = valid_p[W];
	assign ready_p[W]   = m_tready;
	assign wide_product = {acc_p[W][W-1:0], low_p[W]};

	generate
		if (PW >= OW) begin : g_cut_out
			assign m_tdata = wide_product[OW-1:0];
		end else begin : g_pad_out
			assign m_tdata = {{(OW - PW){1'b0}}, wide_product};
		end
	endgenerate

endmodule

// File: tb/sv/booth_signed_multiplier_tb.sv
// self-checking stream testbench for the radix-2 booth signed multiplier
module booth_signed_multiplier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FIELD_W   = bsm_pkg::FIELD_W;
	localparam int unsigned PRODUCT_W = bsm_pkg::PRODUCT_W;
	localparam int unsigned S_DATA_W  = bsm_pkg::S_DATA_W;
	localparam int unsigned M_DATA_W  = bsm_pkg::M_DATA_W;

	localparam int unsigned RAND_ITEMS = 2000;
	localparam int unsigned QUIET_FROM = 1700;
	localparam int unsigned DRAIN_AT   = 1000;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 40;

	// one directed row: operands, and the product where it is known by hand
	typedef struct packed {
		logic [FIELD_W-1:0]   first_operand;
		logic [FIELD_W-1:0]   second_operand;
		logic                 typed;
		logic [PRODUCT_W-1:0] product;
	} operand_row_t;

	localparam int unsigned NUM_ROWS = 22;
	localparam operand_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{16'h0000, 16'h0000, 1'b1, 32'h0000_0000},
		'{16'h0001, 16'h0001, 1'b1, 32'h0000_0001},
		'{16'hFFFF, 16'hFFFF, 1'b1, 32'h0000_0001},
		'{16'h8000, 16'h8000, 1'b1, 32'h4000_0000},
		'{16'h8000, 16'h7FFF, 1'b1, 32'hC000_8000},
		'{16'h7FFF, 16'h8000, 1'b1, 32'hC000_8000},
		'{16'h7FFF, 16'h7FFF, 1'b1, 32'h3FFF_0001},
		'{16'h8000, 16'h0001, 1'b1, 32'hFFFF_8000},
		'{16'h0001, 16'h8000, 1'b1, 32'hFFFF_8000},
		'{16'h8000, 16'hFFFF, 1'b1, 32'h0000_8000},
		'{16'hFFFF, 16'h8000, 1'b1, 32'h0000_8000},
		'{16'h0000, 16'h8000, 1'b1, 32'h0000_0000},
		'{16'h8000, 16'h0000, 1'b1, 32'h0000_0000},
		'{16'hFFFF, 16'h7FFF, 1'b1, 32'hFFFF_8001},
		'{16'h7FFF, 16'hFFFF, 1'b1, 32'hFFFF_8001},
		'{16'hFFFF, 16'h0001, 1'b1, 32'hFFFF_FFFF},
		'{16'h8001, 16'h8001, 1'b1, 32'h3FFF_0001},
		'{16'h5555, 16'hAAAA, 1'b0, 32'h0},
		'{16'hAAAA, 16'h5555, 1'b0, 32'h0},
		'{16'h1234, 16'h5678, 1'b0, 32'h0},
		'{16'h00FF, 16'hFF00, 1'b0, 32'h0},
		'{16'h0003, 16'h0007, 1'b0, 32'h0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;

	logic [PRODUCT_W-1:0] product_q [$];
	int unsigned          error_count = 0;
	int unsigned          cycle_count = 0;
	bit                   idle_en = 1'b1;

	booth_signed_multiplier DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock and a single reset pulse
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// radix-2 booth product with a 17-bit high half
	function automatic logic [PRODUCT_W-1:0] booth_product(
		input logic [FIELD_W-1:0] multiplicand,
		input logic [FIELD_W-1:0] multiplier
	);
		logic [FIELD_W:0]   addend;
		logic [FIELD_W:0]   high;
		logic [FIELD_W-1:0] low;
		logic               prev;
		bsm_pkg::booth_op_t op;
		addend = {multiplicand[FIELD_W-1], multiplicand};
		high = '0;
		low = multiplier;
		prev = 1'b0;
		for (int i = 0; i < FIELD_W; i++) begin
			case ({low[0], prev})
				2'b10: op = bsm_pkg::BOOTH_SUB;
				2'b01: op = bsm_pkg::BOOTH_ADD;
				default: op = bsm_pkg::BOOTH_HOLD;
			endcase
			if (op == bsm_pkg::BOOTH_SUB) begin
				high = high - addend;
			end else if (op == bsm_pkg::BOOTH_ADD) begin
				high = high + addend;
			end
			prev = low[0];
			// the bit crossing into the low half is always the high half's low bit
			low = {high[0], low[FIELD_W-1:1]};
			high = {high[FIELD_W], high[FIELD_W:1]};
		end
		return {high[FIELD_W-1:0], low};
	endfunction

	// random operand biased toward extremes, small values and bit patterns
	function automatic logic [FIELD_W-1:0] pick_operand();
		logic [FIELD_W-1:0] val;
		int unsigned        lo;
		int unsigned        hi;
		case ($urandom_range(0, 9))
			6: begin
				case ($urandom_range(0, 4))
					0: val = 16'h8000;
					1: val = 16'h7FFF;
					2: val = 16'hFFFF;
					3: val = 16'h0001;
					default: val = 16'h0000;
				endcase
			end
			7: val = FIELD_W'($urandom_range(0, 31)) - FIELD_W'(16);
			8: begin
				val = FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
				if ($urandom_range(0, 1) == 1) val = -val;
			end
			9: begin
				// one run of ones, so the recoding sees long hold stretches
				lo = $urandom_range(0, FIELD_W - 1);
				hi = $urandom_range(lo, FIELD_W - 1);
				val = '0;
				for (int b = lo; b <= hi; b++) val[b] = 1'b1;
			end
			default: val = FIELD_W'($urandom);
		endcase
		return val;
	endfunction

	// offer one item, idling first at random, and record its product once taken
	task automatic send_operands(
		input logic [FIELD_W-1:0]   first_operand,
		input logic [FIELD_W-1:0]   second_operand,
		input logic [PRODUCT_W-1:0] product
	);
		int unsigned gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {second_operand, first_operand};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		product_q.push_back(product);
	endtask

	// stimulus: directed table, then random items with one full drain
	initial begin
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int r = 0; r < NUM_ROWS; r++) begin
			a = DIRECTED_ROWS[r].first_operand;
			b = DIRECTED_ROWS[r].second_operand;
			send_operands(a, b, DIRECTED_ROWS[r].typed ? DIRECTED_ROWS[r].product
				: booth_product(a, b));
		end
		for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
			if (n == DRAIN_AT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (product_q.size() != 0) @(posedge clk);
			end
			if (n == QUIET_FROM) idle_en = 1'b0;
			a = pick_operand();
			b = pick_operand();
			send_operands(a, b, booth_product(a, b));
		end
		s_tvalid <= 1'b0;
		while (product_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// receiver back-pressure in random bursts
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (idle_en && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// compare each product item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (product_q.size() == 0) begin
				$error("product %h arrived with none expected", m_tdata);
				error_count++;
			end else if (m_tdata !== product_q[0]) begin
				$error("product mismatch: expected %h, actual %h", product_q[0], m_tdata);
				error_count++;
				void'(product_q.pop_front());
			end else begin
				void'(product_q.pop_front());
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// File: sim.f
sv/bsm_pkg.sv
sv/bsm_step.sv
sv/booth_signed_multiplier.sv
tb/sv/booth_signed_multiplier_tb.sv
